// ----- sv/vertex_color_modifier_top_defines.svh -----
// Assertion macros for the vertex color modifier
`ifndef VERTEX_COLOR_MODIFIER_TOP_DEFINES_SVH
`define VERTEX_COLOR_MODIFIER_TOP_DEFINES_SVH

`ifndef SYNTH
`define VCM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define VCM_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define VCM_ASSERT(lbl, prop, msg)
`define VCM_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ----- sv/vcm_pkg.sv -----
package vcm_pkg;

    localparam int CW = 57;   // width of the dot term c, signed
    localparam int QW = 26;   // quotient bits of the rescale divide
    localparam int DW = 33;   // width of |range_high - range_low|

    localparam logic [3:0] KIND_COLOR_SET       = 4'd0;
    localparam logic [3:0] KIND_ALPHA_SET       = 4'd1;
    localparam logic [3:0] KIND_COLOR_SCALE     = 4'd2;
    localparam logic [3:0] KIND_ALPHA_SCALE     = 4'd3;
    localparam logic [3:0] KIND_COLOR_DOT       = 4'd4;
    localparam logic [3:0] KIND_COLOR_DOT_RS    = 4'd5;
    localparam logic [3:0] KIND_ALPHA_DOT       = 4'd6;
    localparam logic [3:0] KIND_ALPHA_DOT_RS    = 4'd7;
    localparam logic [3:0] KIND_COLOR_SQ        = 4'd8;
    localparam logic [3:0] KIND_COLOR_SQ_RS     = 4'd9;
    localparam logic [3:0] KIND_ALPHA_SQ        = 4'd10;
    localparam logic [3:0] KIND_ALPHA_SQ_RS     = 4'd11;
    localparam logic [3:0] KIND_PASS            = 4'd12;

    localparam logic [2:0] REG_MOD_KIND   = 3'd0;
    localparam logic [2:0] REG_VEC_X      = 3'd1;
    localparam logic [2:0] REG_VEC_Y      = 3'd2;
    localparam logic [2:0] REG_VEC_Z      = 3'd3;
    localparam logic [2:0] REG_RANGE_LOW  = 3'd4;
    localparam logic [2:0] REG_RANGE_HIGH = 3'd5;

    localparam logic signed [32:0]   MULT_SAT   = 33'sd33554432;
    localparam logic signed [CW-1:0] MULT_SAT_W = 57'sd33554432;
    localparam logic signed [32:0]   ONE_Q16    = 33'sd65536;

    typedef struct packed {
        logic [3:0]         kind;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic signed [31:0] range_low;
        logic signed [31:0] range_high;
    } t_cfg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       batch_end;
    } t_pix;

    function automatic logic is_square(input logic [3:0] k);
        logic r;
        case (k) inside
            KIND_COLOR_SQ, KIND_COLOR_SQ_RS, KIND_ALPHA_SQ, KIND_ALPHA_SQ_RS: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_rescale(input logic [3:0] k);
        logic r;
        case (k) inside
            KIND_COLOR_DOT_RS, KIND_ALPHA_DOT_RS, KIND_COLOR_SQ_RS, KIND_ALPHA_SQ_RS: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic signed [32:0] sat_mult(input logic signed [CW-1:0] x);
        logic signed [32:0] r;
        if (x > MULT_SAT_W) begin
            r = MULT_SAT;
        end else if (x < -MULT_SAT_W) begin
            r = -MULT_SAT;
        end else begin
            r = 33'(x);
        end
        return r;
    endfunction

endpackage

// ----- sv/vcm_dot.sv -----
module vcm_dot import vcm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_ce,
    input  logic                 i_valid,
    input  logic signed [15:0]   i_nx,
    input  logic signed [15:0]   i_ny,
    input  logic signed [15:0]   i_nz,
    input  t_pix                 i_pix,
    input  t_cfg                 i_cfg,
    output logic                 o_valid,
    output logic signed [CW-1:0] o_c,
    output t_pix                 o_pix
);

    logic [3:0] r_v;

    logic signed [47:0] r_a_px, r_a_py, r_a_pz;
    t_pix               r_a_pix;
    logic signed [36:0] r_b_c;
    t_pix               r_b_pix;
    logic [39:0]        r_c_aa;
    logic [35:0]        r_c_ab;
    logic [31:0]        r_c_bb;
    logic signed [36:0] r_c_c;
    t_pix               r_c_pix;
    logic signed [CW-1:0] r_d_c;
    t_pix               r_d_pix;

    logic signed [49:0] n_dot;
    logic [49:0]        n_mag;
    logic [35:0]        n_rnd;
    logic signed [36:0] n_c;
    logic [35:0]        n_cm;
    logic [55:0]        n_sq;
    logic [32:0]        n_bb_r;

    always_comb begin
        n_dot = 50'(r_a_px) + 50'(r_a_py) + 50'(r_a_pz);
        n_mag = n_dot[49] ? 50'(-n_dot) : 50'(n_dot);
        n_rnd = 36'((n_mag + 50'd8192) >> 14);
        n_c   = n_dot[49] ? -$signed({1'b0, n_rnd}) : $signed({1'b0, n_rnd});
        n_cm  = r_b_c[36] ? 36'(-r_b_c) : 36'(r_b_c);
        // square = a*a*2^16 + 2ab + round(b*b / 2^16)
        n_bb_r = (33'(r_c_bb) + 33'h8000) >> 16;
        n_sq   = (56'(r_c_aa) << 16) + (56'(r_c_ab) << 1) + 56'(n_bb_r);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ce) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_a_px  <= i_nx * i_cfg.vec_x;
            r_a_py  <= i_ny * i_cfg.vec_y;
            r_a_pz  <= i_nz * i_cfg.vec_z;
            r_a_pix <= i_pix;
            r_b_c   <= n_c;
            r_b_pix <= r_a_pix;
            r_c_aa  <= n_cm[35:16] * n_cm[35:16];
            r_c_ab  <= n_cm[35:16] * n_cm[15:0];
            r_c_bb  <= n_cm[15:0] * n_cm[15:0];
            r_c_c   <= r_b_c;
            r_c_pix <= r_b_pix;
            r_d_c   <= is_square(i_cfg.kind) ? $signed({1'b0, n_sq}) : CW'(r_c_c);
            r_d_pix <= r_c_pix;
        end
    end

    assign o_valid = r_v[3];
    assign o_c     = r_d_c;
    assign o_pix   = r_d_pix;

endmodule

// ----- sv/vcm_div.sv -----
module vcm_div import vcm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_ce,
    input  logic                 i_valid,
    input  logic signed [CW-1:0] i_c,
    input  t_pix                 i_pix,
    input  t_cfg                 i_cfg,
    output logic                 o_valid,
    output logic [QW-1:0]        o_q,
    output logic                 o_sat,
    output logic                 o_neg,
    output logic signed [CW-1:0] o_c,
    output t_pix                 o_pix
);

    typedef struct packed {
        logic [DW-1:0]        rem;
        logic [QW-1:0]        nlo;
        logic [QW-1:0]        q;
        logic                 sat;
        logic                 neg;
        logic signed [CW-1:0] c;
        t_pix                 pix;
    } t_dstage;

    logic [DW-1:0]        r_dm;
    logic                 r_e_v;
    logic [CW-1:0]        r_e_nm;
    logic                 r_e_neg;
    logic signed [CW-1:0] r_e_c;
    t_pix                 r_e_pix;

    logic    r_v  [0:QW];
    t_dstage r_st [0:QW];

    logic signed [CW:0]   n_num;
    logic signed [DW:0]   n_den;
    logic [CW+15:0]       n_big;

    always_comb begin
        n_num = (CW+1)'(i_c) - (CW+1)'(i_cfg.range_low);
        n_den = (DW+1)'(i_cfg.range_high) - (DW+1)'(i_cfg.range_low);
        n_big = {r_e_nm, 16'b0} + (CW+16)'(r_dm >> 1);
    end

    always_ff @(posedge i_clk) begin
        r_dm <= n_den[DW] ? DW'(-n_den) : DW'(n_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
            r_v[0] <= 1'b0;
        end else if (i_ce) begin
            r_e_v <= i_valid;
            r_v[0] <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_e_nm  <= n_num[CW] ? CW'(-n_num) : CW'(n_num);
            r_e_neg <= n_num[CW] ^ n_den[DW];
            r_e_c   <= i_c;
            r_e_pix <= i_pix;
            // quotient stays below 2^QW unless saturated, so the top part is a valid remainder
            r_st[0].rem <= n_big[QW +: DW];
            r_st[0].nlo <= n_big[QW-1:0];
            r_st[0].q   <= '0;
            r_st[0].sat <= r_e_nm >= (CW'(r_dm) << 9);
            r_st[0].neg <= r_e_neg;
            r_st[0].c   <= r_e_c;
            r_st[0].pix <= r_e_pix;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DW:0]   n_t;
        logic          n_ge;
        always_comb begin
            n_t  = {r_st[k].rem, r_st[k].nlo[QW-1]};
            n_ge = n_t >= {1'b0, r_dm};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_ce) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_st[k+1].rem <= n_ge ? DW'(n_t - {1'b0, r_dm}) : n_t[DW-1:0];
                r_st[k+1].nlo <= {r_st[k].nlo[QW-2:0], 1'b0};
                r_st[k+1].q   <= {r_st[k].q[QW-2:0], n_ge};
                r_st[k+1].sat <= r_st[k].sat;
                r_st[k+1].neg <= r_st[k].neg;
                r_st[k+1].c   <= r_st[k].c;
                r_st[k+1].pix <= r_st[k].pix;
            end
        end
    end

    assign o_valid = r_v[QW];
    assign o_q     = r_st[QW].q;
    assign o_sat   = r_st[QW].sat;
    assign o_neg   = r_st[QW].neg;
    assign o_c     = r_st[QW].c;
    assign o_pix   = r_st[QW].pix;

endmodule

// ----- sv/vcm_color.sv -----
module vcm_color import vcm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_ce,
    input  logic                 i_valid,
    input  logic [QW-1:0]        i_q,
    input  logic                 i_sat,
    input  logic                 i_neg,
    input  logic signed [CW-1:0] i_c,
    input  t_pix                 i_pix,
    input  t_cfg                 i_cfg,
    output logic                 o_valid,
    output logic [31:0]          o_rgba,
    output logic                 o_batch_end,
    output logic                 o_fault
);

    logic               r_g_v, r_h_v, r_o_v;
    logic signed [32:0] r_g_a [4];
    logic [7:0]         r_g_b [4];
    logic               r_g_fault, r_g_last;
    logic signed [42:0] r_h_p [4];
    logic               r_h_fault, r_h_last;
    logic [7:0]         r_o_ch [4];
    logic               r_o_fault, r_o_last;

    logic               n_zero;
    logic [32:0]        n_r;
    logic signed [32:0] n_cm;
    logic signed [32:0] n_a [4];
    logic [7:0]         n_b [4];
    logic [7:0]         n_color [4];
    logic signed [31:0] n_sval [3];

    always_comb begin
        n_zero = i_cfg.range_high == i_cfg.range_low;
        n_r    = i_sat ? MULT_SAT : ((33'(i_q) > MULT_SAT) ? MULT_SAT : 33'(i_q));
        if (is_rescale(i_cfg.kind)) begin
            n_cm = n_zero ? 33'sd0 : (i_neg ? -$signed(n_r) : $signed(n_r));
        end else begin
            n_cm = sat_mult(i_c);
        end

        n_color[0] = i_pix.red;
        n_color[1] = i_pix.green;
        n_color[2] = i_pix.blue;
        n_color[3] = i_pix.alpha;
        n_sval[0]  = i_cfg.vec_x;
        n_sval[1]  = i_cfg.vec_y;
        n_sval[2]  = i_cfg.vec_z;

        for (int i = 0; i < 3; i++) begin
            n_b[i] = n_color[i];
            case (i_cfg.kind) inside
                KIND_COLOR_SET: begin
                    n_a[i] = 33'(n_sval[i]);
                    n_b[i] = 8'd255;
                end
                KIND_COLOR_SCALE: n_a[i] = sat_mult(CW'(n_sval[i]));
                KIND_COLOR_DOT, KIND_COLOR_DOT_RS, KIND_COLOR_SQ, KIND_COLOR_SQ_RS:
                    n_a[i] = n_cm;
                default: n_a[i] = ONE_Q16;
            endcase
        end

        n_b[3] = n_color[3];
        case (i_cfg.kind) inside
            KIND_ALPHA_SET: begin
                n_a[3] = 33'(i_cfg.vec_x);
                n_b[3] = 8'd255;
            end
            KIND_ALPHA_SCALE: n_a[3] = sat_mult(CW'(i_cfg.vec_x));
            KIND_ALPHA_DOT, KIND_ALPHA_DOT_RS, KIND_ALPHA_SQ, KIND_ALPHA_SQ_RS:
                n_a[3] = n_cm;
            default: n_a[3] = ONE_Q16;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v <= 1'b0;
            r_h_v <= 1'b0;
            r_o_v <= 1'b0;
        end else if (i_ce) begin
            r_g_v <= i_valid;
            r_h_v <= r_g_v;
            r_o_v <= r_h_v;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [43:0] v;
        if (i_ce) begin
            for (int i = 0; i < 4; i++) begin
                r_g_a[i] <= n_a[i];
                r_g_b[i] <= n_b[i];
                r_h_p[i] <= r_g_a[i] * $signed({1'b0, r_g_b[i]});
                // round to nearest, clamp to a byte
                v = 44'(r_h_p[i]) + 44'sd32768;
                if (v[43]) begin
                    r_o_ch[i] <= 8'd0;
                end else if (v[42:24] != '0) begin
                    r_o_ch[i] <= 8'd255;
                end else begin
                    r_o_ch[i] <= v[23:16];
                end
            end
            r_g_fault <= is_rescale(i_cfg.kind) && n_zero;
            r_g_last  <= i_pix.batch_end;
            r_h_fault <= r_g_fault;
            r_h_last  <= r_g_last;
            r_o_fault <= r_h_fault;
            r_o_last  <= r_h_last;
        end
    end

    assign o_valid     = r_o_v;
    assign o_rgba      = {r_o_ch[3], r_o_ch[2], r_o_ch[1], r_o_ch[0]};
    assign o_batch_end = r_o_last;
    assign o_fault     = r_o_fault;

endmodule

// ----- sv/vertex_color_modifier_top.sv -----
// Throughput: one item per cycle; the whole pipeline advances together and
// holds while a finished result waits for i_m_tready.
// The rescale divide is a 26-stage one-bit-per-stage pipeline, the longest part.
// Reset (synchronous, active low) empties the pipeline and loads mod_kind 12,
// vectors and range_low 0, range_high 1.0.
`include "vertex_color_modifier_top_defines.svh"
module vertex_color_modifier_top import vcm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // normal_x[15:0], normal_y[31:16], normal_z[47:32], red_in[55:48],
    // green_in[63:56], blue_in[71:64], alpha_in[79:72]
    input  logic [79:0] i_s_tdata,
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // red_out[7:0], green_out[15:8], blue_out[23:16], alpha_out[31:24]
    output logic [31:0] o_m_tdata,
    output logic        o_m_tlast,
    // range_fault[0]
    output logic        o_m_tuser,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata
);

    t_cfg r_cfg;
    logic ce;
    t_pix in_pix;

    logic                 dot_valid;
    logic signed [CW-1:0] dot_c;
    t_pix                 dot_pix;
    logic                 div_valid, div_sat, div_neg;
    logic [QW-1:0]        div_q;
    logic signed [CW-1:0] div_c;
    t_pix                 div_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kind       <= KIND_PASS;
            r_cfg.vec_x      <= '0;
            r_cfg.vec_y      <= '0;
            r_cfg.vec_z      <= '0;
            r_cfg.range_low  <= '0;
            r_cfg.range_high <= 32'sd65536;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MOD_KIND:   r_cfg.kind       <= i_cfg_wdata[3:0];
                REG_VEC_X:      r_cfg.vec_x      <= i_cfg_wdata;
                REG_VEC_Y:      r_cfg.vec_y      <= i_cfg_wdata;
                REG_VEC_Z:      r_cfg.vec_z      <= i_cfg_wdata;
                REG_RANGE_LOW:  r_cfg.range_low  <= i_cfg_wdata;
                REG_RANGE_HIGH: r_cfg.range_high <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // advance whenever the output slot is free or being drained
    assign ce         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = ce;

    assign in_pix.red       = i_s_tdata[55:48];
    assign in_pix.green     = i_s_tdata[63:56];
    assign in_pix.blue      = i_s_tdata[71:64];
    assign in_pix.alpha     = i_s_tdata[79:72];
    assign in_pix.batch_end = i_s_tlast;

    vcm_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (i_s_tvalid),
        .i_nx    ($signed(i_s_tdata[15:0])),
        .i_ny    ($signed(i_s_tdata[31:16])),
        .i_nz    ($signed(i_s_tdata[47:32])),
        .i_pix   (in_pix),
        .i_cfg   (r_cfg),
        .o_valid (dot_valid),
        .o_c     (dot_c),
        .o_pix   (dot_pix)
    );

    vcm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (dot_valid),
        .i_c     (dot_c),
        .i_pix   (dot_pix),
        .i_cfg   (r_cfg),
        .o_valid (div_valid),
        .o_q     (div_q),
        .o_sat   (div_sat),
        .o_neg   (div_neg),
        .o_c     (div_c),
        .o_pix   (div_pix)
    );

    vcm_color u_color (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ce        (ce),
        .i_valid     (div_valid),
        .i_q         (div_q),
        .i_sat       (div_sat),
        .i_neg       (div_neg),
        .i_c         (div_c),
        .i_pix       (div_pix),
        .i_cfg       (r_cfg),
        .o_valid     (o_m_tvalid),
        .o_rgba      (o_m_tdata),
        .o_batch_end (o_m_tlast),
        .o_fault     (o_m_tuser)
    );

    `VCM_ASSERT(a_fault_range, o_m_tvalid && o_m_tuser |-> r_cfg.range_high == r_cfg.range_low, "fault with distinct range ends")
    `VCM_ASSERT(a_fault_kind, o_m_tvalid && o_m_tuser |-> is_rescale(r_cfg.kind), "fault outside a rescaled mode")
    `VCM_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_m_tvalid, "result valid right after reset")

endmodule
